### design/knap_pkg.sv
// shared types and constants for the knapsack table solver
package knap_pkg;

    localparam int CAP_W   = 11;
    localparam int VALUE_W = 16;
    localparam int TABLE_W = 32;

    // register indexes on the configuration port
    localparam logic REG_CAPACITY = 1'b0;

    // controller state codes
    typedef logic [2:0] state_t;
    localparam state_t ST_CLEAR  = 3'd0;
    localparam state_t ST_IDLE   = 3'd1;
    localparam state_t ST_SWEEP  = 3'd2;
    localparam state_t ST_DRAIN  = 3'd3;
    localparam state_t ST_RDRES  = 3'd4;
    localparam state_t ST_RESULT = 3'd5;

    // memory port controls from the sequencer
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### design/knap_cfg.sv
// configuration register port holding the knapsack capacity
module knap_cfg
    import knap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [CAP_W-1:0]   capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = {{(32-CAP_W){1'b0}}, capacity_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign capacity = capacity_reg;

endmodule

### design/knap_mem.sv
// best-value table: one write port, two registered read ports
module knap_mem
    import knap_pkg::*;
#(
    parameter int DEPTH  = 1025,
    parameter int ADDR_W = 11
)
(
    input  logic               clk,
    input  mem_ctl_t           ctl,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [TABLE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]  raddr_a,
    input  logic [ADDR_W-1:0]  raddr_b,
    output logic [TABLE_W-1:0] rdata_a,
    output logic [TABLE_W-1:0] rdata_b
);

    logic [TABLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### design/knap_upd.sv
// entry update: keep the old value or take the saturated sum, whichever is larger
module knap_upd
    import knap_pkg::*;
(
    input  logic [TABLE_W-1:0] old_value,
    input  logic [TABLE_W-1:0] lower_value,
    input  logic [VALUE_W-1:0] item_value,
    output logic [TABLE_W-1:0] new_value
);

    logic [TABLE_W:0]   sum;
    logic [TABLE_W-1:0] cand;

    assign sum  = {1'b0, lower_value} + {{(TABLE_W+1-VALUE_W){1'b0}}, item_value};
    assign cand = sum[TABLE_W] ? {TABLE_W{1'b1}} : sum[TABLE_W-1:0];

    assign new_value = (cand > old_value) ? cand : old_value;

endmodule

### design/knap_ctrl.sv
// sequencer: table clear, per-object capacity sweep and result readout
module knap_ctrl
    import knap_pkg::*;
#(
    parameter int MAX_CAPACITY = 1024,
    parameter int ADDR_W       = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CAP_W-1:0]    item_weight,
    input  logic [VALUE_W-1:0]  item_value,
    input  logic                last_item,
    input  logic [CAP_W-1:0]    capacity,
    output logic                busy,
    output logic                done,
    output logic [TABLE_W-1:0]  best_value,
    output mem_ctl_t            mem_ctl,
    output logic [ADDR_W-1:0]   waddr,
    output logic [TABLE_W-1:0]  wdata,
    output logic [ADDR_W-1:0]   raddr_a,
    output logic [ADDR_W-1:0]   raddr_b,
    input  logic [TABLE_W-1:0]  rdata_a,
    input  logic [TABLE_W-1:0]  upd_value,
    output logic [VALUE_W-1:0]  upd_item_value
);

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MAX_CAPACITY);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic [ADDR_W-1:0]   wt_reg, wt_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next;
    logic [ADDR_W-1:0]   cap_reg, cap_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                last_reg, last_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]   s1_addr_reg, s1_addr_next;
    logic                done_reg, done_next;
    logic [TABLE_W-1:0]  best_reg, best_next;

    logic [31:0] cap_wide;
    logic [31:0] lo_wide;
    logic        has_work;

    assign cap_wide = (32'(capacity) > 32'(MAX_CAPACITY)) ? 32'(MAX_CAPACITY)
                                                          : 32'(capacity);
    assign lo_wide  = (item_weight == '0) ? 32'd1 : 32'(item_weight);
    assign has_work = (cap_wide >= lo_wide);

    always_comb
    begin
        state_next    = state_reg;
        j_next        = j_reg;
        wt_next       = wt_reg;
        lo_next       = lo_reg;
        cap_next      = cap_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        s1_valid_next = 1'b0;
        s1_addr_next  = j_reg;
        done_next     = 1'b0;
        best_next     = best_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (j_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cap_next  = cap_wide[ADDR_W-1:0];
                    wt_next   = ADDR_W'(item_weight) & {ADDR_W{has_work}};
                    lo_next   = lo_wide[ADDR_W-1:0];
                    val_next  = item_value;
                    last_next = last_item;
                    j_next    = cap_wide[ADDR_W-1:0];
                    if (has_work)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (last_item)
                    begin
                        state_next = ST_RDRES;
                    end
                end
            end
            ST_SWEEP:
            begin
                // reads for entry j go out now, the write follows next cycle
                s1_valid_next = 1'b1;
                if (j_reg == lo_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_RDRES : ST_IDLE;
            end
            ST_RDRES:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                best_next  = rdata_a;
                done_next  = 1'b1;
                j_next     = TOP_ADDR;
                state_next = ST_CLEAR;
            end
            default:
            begin
                j_next     = TOP_ADDR;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            j_reg        <= TOP_ADDR;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            s1_valid_reg <= s1_valid_next;
            done_reg     <= done_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wt_reg      <= wt_next;
        lo_reg      <= lo_next;
        cap_reg     <= cap_next;
        val_reg     <= val_next;
        s1_addr_reg <= s1_addr_next;
        best_reg    <= best_next;
    end

    // memory access
    always_comb
    begin
        mem_ctl.we = 1'b0;
        mem_ctl.re = 1'b0;
        waddr      = s1_addr_reg;
        wdata      = upd_value;
        raddr_a    = j_reg;
        raddr_b    = j_reg - wt_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_ctl.we = 1'b1;
            waddr      = j_reg;
            wdata      = '0;
        end
        else if (s1_valid_reg)
        begin
            mem_ctl.we = 1'b1;
        end
        if (state_reg == ST_SWEEP)
        begin
            mem_ctl.re = 1'b1;
        end
        else if (state_reg == ST_RDRES)
        begin
            mem_ctl.re = 1'b1;
            raddr_a    = cap_reg;
            raddr_b    = cap_reg;
        end
    end

    assign upd_item_value = val_reg;
    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign best_value     = best_reg;

endmodule

### design/knapsack_01_dp.sv
// top level of the 0/1 knapsack best-value solver
//
// usage: set the capacity register over the APB port (byte address 0) while
// the block is idle, then feed objects one per request: item_weight and
// item_value with start while busy is low. last_item marks the final object.
// after the last object the block pulses done for one cycle with best_value,
// the best total value at the capacity (saturated at 32 bits).
// per object: the request is accepted, then one table read-modify-write per
// entry from the capacity down to max(weight,1), then a drain step retires
// the last write; when nothing fits, only the acceptance takes place.
// the rate is set by the table memory: one entry update per cycle through
// its two read ports and one write port.
// a last object then reads the result at the capacity, followed by a clearing
// pass that zeroes every entry; done shows with the first write of that pass.
// after reset the same clearing pass runs with busy high; configuration
// writes are taken throughout.
// the receiver cannot stall: done lasts exactly one cycle.
module knapsack_01_dp
    import knap_pkg::*;
#(
    parameter int MAX_CAPACITY = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CAP_W-1:0]   item_weight,
    input  logic [VALUE_W-1:0] item_value,
    input  logic               last_item,
    output logic               done,
    output logic [TABLE_W-1:0] best_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH  = MAX_CAPACITY + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CAP_W-1:0]   capacity;
    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [TABLE_W-1:0] wdata;
    logic [TABLE_W-1:0] rdata_a;
    logic [TABLE_W-1:0] rdata_b;
    logic [TABLE_W-1:0] upd_value;
    logic [VALUE_W-1:0] upd_item_value;

    knap_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    knap_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    knap_upd u_upd (
        .old_value   (rdata_a),
        .lower_value (rdata_b),
        .item_value  (upd_item_value),
        .new_value   (upd_value)
    );

    knap_ctrl #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .item_weight    (item_weight),
        .item_value     (item_value),
        .last_item      (last_item),
        .capacity       (capacity),
        .busy           (busy),
        .done           (done),
        .best_value     (best_value),
        .mem_ctl        (mem_ctl),
        .waddr          (waddr),
        .wdata          (wdata),
        .raddr_a        (raddr_a),
        .raddr_b        (raddr_b),
        .rdata_a        (rdata_a),
        .upd_value      (upd_value),
        .upd_item_value (upd_item_value)
    );

    // the result comes out while the clearing pass has started
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // a write-back never lands on an entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.we && mem_ctl.re) |-> (waddr != raddr_a && waddr != raddr_b))
        else $error("table write collides with a read");

    // an accepted last object always takes the block out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_item) |=> busy)
        else $error("last object accepted without starting the result sequence");

endmodule
